@@ rtl/assert_macros.svh @@
// Assertion helpers, clocked on clk and disabled during rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/tks_pkg.sv @@
`default_nettype none

package tks_pkg;

  localparam int TKS_MAX_K    = 16;
  localparam int TKS_MAX_DOCS = 65536;

  localparam int SCORE_W     = 32;
  localparam int INDEX_W     = 16;
  localparam int TOP_COUNT_W = 5;

  localparam logic [TOP_COUNT_W-1:0] TOP_COUNT_RESET = 5'd10;

  typedef enum logic [0:0] {
    ST_COLLECT,
    ST_EMIT
  } tks_state_t;

  // Broadcast control to every cell of the chain.
  typedef struct packed {
    logic insert;  // place the new score, push lower entries right
    logic shift;   // emission: every cell takes its right neighbor
  } cell_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/tks_doc_if.sv @@
`default_nettype none

interface tks_doc_if;
  import tks_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [SCORE_W-1:0] score;
  logic                      last_doc;

  modport source (output valid, output score, output last_doc, input ready);
  modport sink   (input valid, input score, input last_doc, output ready);
endinterface

`default_nettype wire

@@ rtl/tks_rank_if.sv @@
`default_nettype none

interface tks_rank_if;
  import tks_pkg::*;

  logic               valid;
  logic               ready;
  logic [INDEX_W-1:0] doc_index;
  logic               rank_last;

  modport source (output valid, output doc_index, output rank_last, input ready);
  modport sink   (input valid, input doc_index, input rank_last, output ready);
endinterface

`default_nettype wire

@@ rtl/tks_cell.sv @@
`default_nettype none

module tks_cell (
  input  logic                               clk,
  input  tks_pkg::cell_ctrl_t                ctrl,
  input  logic                               occupied,
  input  logic signed [tks_pkg::SCORE_W-1:0] new_score,
  input  logic        [tks_pkg::INDEX_W-1:0] new_index,
  input  logic                               left_take,
  input  logic signed [tks_pkg::SCORE_W-1:0] left_score,
  input  logic        [tks_pkg::INDEX_W-1:0] left_index,
  input  logic signed [tks_pkg::SCORE_W-1:0] right_score,
  input  logic        [tks_pkg::INDEX_W-1:0] right_index,
  output logic                               take,
  output logic signed [tks_pkg::SCORE_W-1:0] score,
  output logic        [tks_pkg::INDEX_W-1:0] index
);
  import tks_pkg::*;

  // Strictly greater only: ties stay behind the earlier document.
  assign take = occupied ? (new_score > score) : 1'b1;

  always_ff @(posedge clk) begin
    if (ctrl.insert && take) begin
      score <= left_take ? left_score : new_score;
      index <= left_take ? left_index : new_index;
    end else if (ctrl.shift) begin
      score <= right_score;
      index <= right_index;
    end
  end

endmodule

`default_nettype wire

@@ rtl/top_k_score_selector.sv @@
// top_k_score_selector: streaming top-k document selection.
//
// doc (sink): one score per beat, Q16.16 signed, last_doc on the final one.
//   Documents are numbered from 0 per query; beyond MAX_DOCS they are dropped.
// rank (source): the indices of the best min(k, n) documents, best first,
//   rank_last on the final beat. Equal scores: earlier index first.
// top_count_we / top_count_wdata: sets k (0 acts as 1, above MAX_K as MAX_K).
//   Write only while no query is open.
//
// Throughput: one document per cycle while collecting; every cell of the
// chain compares the new score against its own entry in the same cycle and
// hands its take flag and entry to its right neighbor.
// Latency: the first index is valid the cycle after the last document beat.
// doc.ready is low during emission.
// Stall: if rank.ready is low the current index holds; the chain shifts left
// by one cell per taken beat.
// Reset: empty list, counter zero, k = 10, ready to collect.

`default_nettype none

module top_k_score_selector #(
  parameter int MAX_K    = tks_pkg::TKS_MAX_K,
  parameter int MAX_DOCS = tks_pkg::TKS_MAX_DOCS
) (
  input  logic                            clk,
  input  logic                            rst,
  tks_doc_if.sink                         doc,
  tks_rank_if.source                      rank,
  input  logic                            top_count_we,
  input  logic [tks_pkg::TOP_COUNT_W-1:0] top_count_wdata
);
  import tks_pkg::*;

  `include "assert_macros.svh"

  localparam int KW  = $clog2(MAX_K + 1);
  localparam int CNW = $clog2(MAX_DOCS + 1);
  localparam int CW  = (KW > TOP_COUNT_W) ? KW : TOP_COUNT_W;

  tks_state_t             state, state_next;
  logic [TOP_COUNT_W-1:0] top_count;
  logic [KW-1:0]          fill;
  logic [KW-1:0]          remaining;
  logic [CNW-1:0]         doc_counter;

  logic       doc_acc, rank_acc, room;
  cell_ctrl_t ctrl;
  logic [KW-1:0] fill_after;
  logic [CW-1:0] k_req, k_eff, n_emit;

  // Cell chain wiring: element i is the output of cell i.
  logic                      take  [MAX_K];
  logic signed [SCORE_W-1:0] score [MAX_K];
  logic        [INDEX_W-1:0] index [MAX_K];

  assign doc_acc  = doc.valid && doc.ready;
  assign rank_acc = rank.valid && rank.ready;
  assign room     = doc_counter < CNW'(MAX_DOCS);

  assign ctrl.insert = doc_acc && room;
  assign ctrl.shift  = rank_acc;

  // Entries held after this beat's insert; a full list stays full.
  assign fill_after = (ctrl.insert && (fill < KW'(MAX_K))) ? fill + 1'b1 : fill;

  always_comb begin
    k_req = CW'(top_count);
    if (k_req == '0) begin
      k_eff = CW'(1);
    end else if (k_req > CW'(MAX_K)) begin
      k_eff = CW'(MAX_K);
    end else begin
      k_eff = k_req;
    end
    n_emit = (k_eff < CW'(fill_after)) ? k_eff : CW'(fill_after);
  end

  for (genvar i = 0; i < MAX_K; i++) begin : g_cell
    logic                      l_take;
    logic signed [SCORE_W-1:0] l_score, r_score;
    logic        [INDEX_W-1:0] l_index, r_index;

    if (i == 0) begin : g_head
      assign l_take  = 1'b0;
      assign l_score = '0;
      assign l_index = '0;
    end else begin : g_body
      assign l_take  = take[i-1];
      assign l_score = score[i-1];
      assign l_index = index[i-1];
    end

    if (i == MAX_K - 1) begin : g_tail
      assign r_score = '0;
      assign r_index = '0;
    end else begin : g_inner
      assign r_score = score[i+1];
      assign r_index = index[i+1];
    end

    tks_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .occupied    (KW'(i) < fill),
      .new_score   (doc.score),
      .new_index   (INDEX_W'(doc_counter)),
      .left_take   (l_take),
      .left_score  (l_score),
      .left_index  (l_index),
      .right_score (r_score),
      .right_index (r_index),
      .take        (take[i]),
      .score       (score[i]),
      .index       (index[i])
    );
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_COLLECT: if (doc_acc && doc.last_doc) state_next = ST_EMIT;
      ST_EMIT:    if (rank_acc && rank.rank_last) state_next = ST_COLLECT;
      default:    state_next = ST_COLLECT;
    endcase
  end

  // Outputs
  always_comb begin
    doc.ready  = 1'b0;
    rank.valid = 1'b0;
    unique case (state)
      ST_COLLECT: doc.ready  = 1'b1;
      ST_EMIT:    rank.valid = 1'b1;
      default:    doc.ready  = 1'b0;
    endcase
  end

  assign rank.doc_index = index[0];
  assign rank.rank_last = remaining == KW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_COLLECT;
      top_count   <= TOP_COUNT_RESET;
      fill        <= '0;
      remaining   <= '0;
      doc_counter <= '0;
    end else begin
      state <= state_next;
      if (top_count_we) begin
        top_count <= top_count_wdata;
      end
      if (doc_acc) begin
        if (doc.last_doc) begin
          // query closes: count captured, list free for the next query
          remaining   <= KW'(n_emit);
          fill        <= '0;
          doc_counter <= '0;
        end else begin
          fill <= fill_after;
          if (room) begin
            doc_counter <= doc_counter + 1'b1;
          end
        end
      end
      if (rank_acc) begin
        remaining <= remaining - 1'b1;
      end
    end
  end

  `ASSERT_NOW(a_one_side, doc.ready, !rank.valid, "collect and emit overlap")
  `ASSERT_NOW(a_emit_count, rank.valid, remaining != '0, "emitting with no count left")
  `ASSERT_NEXT(a_last_emits, doc_acc && doc.last_doc, rank.valid, "no emission after last doc")
  `ASSERT_NEXT(a_back_collect, rank_acc && rank.rank_last, doc.ready, "not ready after last beat")
  `ASSERT_NOW(a_fill_bound, 1'b1, fill <= KW'(MAX_K), "fill count beyond depth")

endmodule

`default_nettype wire
